/* hdl/swq_pkg.sv */
// Package for the semaphore wait-queue table: command and status codes,
// request and result structs. No dependencies.
package swq_pkg;

    localparam int KEY_W = 31;
    localparam int PID_W = 4;

    typedef enum logic [1:0] {
        CMD_BLOCK  = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] sem_key;
        logic [PID_W-1:0] proc_id;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PID_W-1:0] proc_out;
        logic [4:0]       slots_in_use;
    } rsp_t;

endpackage

/* hdl/swq_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module swq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and registered read (a read during a write returns the old data)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hdl/semaphore_wait_queue_table.sv */
// Semaphore wait-queue table top level: sequencer plus shared key compare.
// Depends on swq_pkg and swq_ram.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the single result appears on rsp for one cycle with done high. The
// receiver cannot stall, so the result must be captured in that cycle. Every
// request first reads the wait record, then scans all slots in turn through
// one key comparator, also noting the lowest free slot, then reads the slot
// head and tail, decides and writes. Block, peek, a failed request and a pop
// that empties its queue then show done; a pop that leaves a queue behind
// first fetches and writes the new head. Remove-given walks the queue link by
// link, passing at most MAX_PROCS links, and unlinks the process it finds.
// Busy drops to idle before the next request is taken. Slot keys, heads,
// tails, next links and wait keys live in memories; active flags and wait
// flags are flip-flops cleared by reset and gate every memory read.
module semaphore_wait_queue_table #(
    parameter int MAX_PROCS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  swq_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output swq_pkg::rsp_t rsp
);
    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int KW = swq_pkg::KEY_W;
    localparam int PW = swq_pkg::PID_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_WKRD  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_SCMP  = 10'b0000001000,
        S_HRD   = 10'b0000010000,
        S_HUSE  = 10'b0000100000,
        S_WALK  = 10'b0001000000,
        S_WCMP  = 10'b0010000000,
        S_FIX   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    swq_pkg::cmd_t     cmd_reg;
    logic [KW-1:0]     key_reg;
    logic [PW-1:0]     pid_reg;
    logic [AW:0]       idx_reg;
    logic [AW-1:0]     slot_reg;
    logic              hit_reg;
    logic [AW-1:0]     free_reg;
    logic              free_any_reg;
    logic [AW-1:0]     cur_reg, prev_reg, tail_reg;
    logic              has_prev_reg;
    logic [AW:0]       steps_reg;
    logic [MAX_PROCS-1:0] active_reg;
    logic [MAX_PROCS-1:0] waiting_reg;
    logic [4:0]        used_reg;
    logic [1:0]        status_reg;
    logic [PW-1:0]     pout_reg;

    // Memory ports
    logic          sk_we, hd_we, tl_we, nx_we, wk_we;
    logic [AW-1:0] sk_a, hd_a, tl_a, nx_a, wk_a;
    logic [KW-1:0] sk_wd, sk_rd, wk_wd, wk_rd;
    logic [AW-1:0] hd_wd, hd_rd, tl_wd, tl_rd, nx_wd, nx_rd;

    swq_ram #(.WIDTH(KW), .DEPTH(MAX_PROCS)) u_key
        (.clk(clk), .we(sk_we), .addr(sk_a), .wdata(sk_wd), .rdata(sk_rd));
    swq_ram #(.WIDTH(AW), .DEPTH(MAX_PROCS)) u_head
        (.clk(clk), .we(hd_we), .addr(hd_a), .wdata(hd_wd), .rdata(hd_rd));
    swq_ram #(.WIDTH(AW), .DEPTH(MAX_PROCS)) u_tail
        (.clk(clk), .we(tl_we), .addr(tl_a), .wdata(tl_wd), .rdata(tl_rd));
    swq_ram #(.WIDTH(AW), .DEPTH(MAX_PROCS)) u_next
        (.clk(clk), .we(nx_we), .addr(nx_a), .wdata(nx_wd), .rdata(nx_rd));
    swq_ram #(.WIDTH(KW), .DEPTH(MAX_PROCS)) u_wkey
        (.clk(clk), .we(wk_we), .addr(wk_a), .wdata(wk_wd), .rdata(wk_rd));

    logic [AW-1:0] pid_a;
    logic          pid_ok;
    logic          wait_ok;
    logic          blk_ok;
    logic [AW-1:0] idx_a;
    logic          key_eq;
    logic [AW:0]   lim;

    assign lim     = (AW + 1)'(MAX_PROCS);
    assign pid_a   = AW'(pid_reg);
    assign pid_ok  = ({{(32-PW){1'b0}}, pid_reg} < 32'(MAX_PROCS));
    assign wait_ok = pid_ok && waiting_reg[pid_a];
    assign blk_ok  = (key_reg != '0) && pid_ok && !waiting_reg[pid_a];
    assign idx_a   = idx_reg[AW-1:0];
    // Shared comparator: scanned slot key against request key
    assign key_eq  = (sk_rd == key_reg);

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp.status       = status_reg;
    assign rsp.proc_out     = (status_reg == swq_pkg::ST_OK) ? pout_reg : '0;
    assign rsp.slots_in_use = used_reg;

    // Next state, memory addresses and write enables
    always_comb
    begin
        sk_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; wk_we = 1'b0;
        sk_a = idx_a; hd_a = slot_reg; tl_a = slot_reg; nx_a = cur_reg;
        wk_a = pid_a;
        sk_wd = key_reg; hd_wd = pid_a; tl_wd = pid_a; nx_wd = pid_a;
        wk_wd = key_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Fetch the wait record of the incoming process
                wk_a = AW'(req.proc_id);
                if (start)
                    state_next = S_WKRD;
            end
            S_WKRD:  state_next = S_SCAN;
            S_SCAN:  state_next = (idx_reg == lim) ? S_HRD : S_SCMP;
            S_SCMP:  state_next = S_SCAN;
            S_HRD:   state_next = S_HUSE;
            S_HUSE:
            begin
                // Link a blocked process in, or open a new slot for it
                if (cmd_reg == swq_pkg::CMD_BLOCK && blk_ok && (hit_reg || free_any_reg))
                begin
                    wk_we = 1'b1;
                    tl_we = 1'b1;
                    if (hit_reg)
                    begin
                        nx_we = 1'b1;
                        nx_a  = tl_rd;
                    end
                    else
                    begin
                        sk_we = 1'b1;
                        hd_we = 1'b1;
                        sk_a  = free_reg;
                        hd_a  = free_reg;
                        tl_a  = free_reg;
                    end
                end
                // Fetch the successor of the head for a pop
                if (cmd_reg == swq_pkg::CMD_POP)
                    nx_a = hd_rd;
                if (cmd_reg == swq_pkg::CMD_POP && key_reg != '0 && hit_reg &&
                    hd_rd != tl_rd)
                    state_next = S_FIX;
                else if (cmd_reg == swq_pkg::CMD_REMOVE && wait_ok && hit_reg)
                    state_next = S_WALK;
                else
                    state_next = S_DONE;
            end
            S_WALK:
            begin
                if (steps_reg == lim)
                    state_next = S_DONE;
                else if (cur_reg == pid_a)
                    state_next = S_FIX;
                else if (cur_reg == tail_reg)
                    state_next = S_DONE;
                else
                    state_next = S_WCMP;
            end
            S_WCMP:  state_next = S_WALK;
            S_FIX:
            begin
                // Unlink the removed process from its queue
                if (cmd_reg == swq_pkg::CMD_POP)
                begin
                    hd_we = 1'b1;
                    hd_wd = nx_rd;
                end
                else if (!has_prev_reg)
                begin
                    if (pid_a != tail_reg)
                    begin
                        hd_we = 1'b1;
                        hd_wd = nx_rd;
                    end
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_a  = prev_reg;
                    nx_wd = nx_rd;
                    if (pid_a == tail_reg)
                    begin
                        tl_we = 1'b1;
                        tl_wd = prev_reg;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= swq_pkg::CMD_BLOCK;
            key_reg      <= '0;
            pid_reg      <= '0;
            idx_reg      <= '0;
            slot_reg     <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= '0;
            free_any_reg <= 1'b0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            tail_reg     <= '0;
            has_prev_reg <= 1'b0;
            steps_reg    <= '0;
            active_reg   <= '0;
            waiting_reg  <= '0;
            used_reg     <= '0;
            status_reg   <= swq_pkg::ST_MISSING;
            pout_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg      <= swq_pkg::cmd_t'(req.cmd);
                        key_reg      <= (req.cmd == swq_pkg::CMD_REMOVE) ? '0 : req.sem_key;
                        pid_reg      <= req.proc_id;
                        idx_reg      <= '0;
                        hit_reg      <= 1'b0;
                        slot_reg     <= '0;
                        free_reg     <= '0;
                        free_any_reg <= 1'b0;
                    end
                end
                S_WKRD:
                begin
                    // Remove-given takes its key from the wait record
                    if (cmd_reg == swq_pkg::CMD_REMOVE && wait_ok)
                        key_reg <= wk_rd;
                end
                S_SCAN:
                begin
                end
                S_SCMP:
                begin
                    if (!hit_reg && active_reg[idx_a] && key_eq)
                    begin
                        hit_reg  <= 1'b1;
                        slot_reg <= idx_a;
                    end
                    if (!free_any_reg && !active_reg[idx_a])
                    begin
                        free_any_reg <= 1'b1;
                        free_reg     <= idx_a;
                    end
                    idx_reg <= idx_reg + (AW + 1)'(1);
                end
                S_HRD:
                begin
                end
                S_HUSE:
                begin
                    status_reg   <= swq_pkg::ST_MISSING;
                    pout_reg     <= '0;
                    cur_reg      <= hd_rd;
                    tail_reg     <= tl_rd;
                    prev_reg     <= '0;
                    has_prev_reg <= 1'b0;
                    steps_reg    <= '0;
                    unique case (cmd_reg)
                        swq_pkg::CMD_BLOCK:
                        begin
                            if (!blk_ok)
                                status_reg <= swq_pkg::ST_INVALID;
                            else if (hit_reg)
                            begin
                                status_reg <= swq_pkg::ST_OK;
                                waiting_reg[pid_a] <= 1'b1;
                            end
                            else if (!free_any_reg)
                                status_reg <= swq_pkg::ST_FULL;
                            else
                            begin
                                status_reg <= swq_pkg::ST_OK;
                                waiting_reg[pid_a] <= 1'b1;
                                active_reg[free_reg] <= 1'b1;
                                used_reg <= used_reg + 5'd1;
                            end
                        end
                        swq_pkg::CMD_POP, swq_pkg::CMD_PEEK:
                        begin
                            if (key_reg == '0)
                                status_reg <= swq_pkg::ST_INVALID;
                            else if (hit_reg)
                            begin
                                status_reg <= swq_pkg::ST_OK;
                                pout_reg   <= PW'(hd_rd);
                                if (cmd_reg == swq_pkg::CMD_POP)
                                begin
                                    waiting_reg[hd_rd] <= 1'b0;
                                    if (hd_rd == tl_rd)
                                    begin
                                        active_reg[slot_reg] <= 1'b0;
                                        used_reg <= used_reg - 5'd1;
                                    end
                                end
                            end
                        end
                        swq_pkg::CMD_REMOVE:
                        begin
                            if (!pid_ok)
                                status_reg <= swq_pkg::ST_INVALID;
                        end
                    endcase
                end
                S_WALK:
                begin
                end
                S_WCMP:
                begin
                    // Advance one link along the queue
                    prev_reg     <= cur_reg;
                    has_prev_reg <= 1'b1;
                    cur_reg      <= nx_rd;
                    steps_reg    <= steps_reg + (AW + 1)'(1);
                end
                S_FIX:
                begin
                    if (cmd_reg == swq_pkg::CMD_REMOVE)
                    begin
                        status_reg <= swq_pkg::ST_OK;
                        pout_reg   <= pid_reg;
                        waiting_reg[pid_a] <= 1'b0;
                        if (!has_prev_reg && pid_a == tail_reg)
                        begin
                            active_reg[slot_reg] <= 1'b0;
                            used_reg <= used_reg - 5'd1;
                        end
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Assertions
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after done");
    a_state_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_used_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (used_reg == 5'($countones(active_reg))))
        else $error("slot count mismatch");
endmodule
